>>> src/mtkhd_pkg.sv
package mtkhd_pkg;

  localparam int unsigned KEY_W  = 4;
  localparam int unsigned MODS_W = 4;
  localparam int unsigned CD_W   = 10;
  localparam int unsigned POS_W  = 3;

  localparam logic [CD_W-1:0] TIMEOUT_RESET = 10'd800;

  // Layer codes carried on the modifier bits.
  localparam logic [MODS_W-1:0] LAYER_LETTER = 4'd0;
  localparam logic [MODS_W-1:0] LAYER_NAV    = 4'd1;
  localparam logic [MODS_W-1:0] LAYER_DIGIT  = 4'd2;
  localparam logic [MODS_W-1:0] LAYER_SYMBOL = 4'd8;
  localparam logic [MODS_W-1:0] LAYER_CTRL   = 4'd9;

  // Key numbers with a fixed meaning.
  localparam logic [KEY_W-1:0] KEY_NONE      = 4'd0;
  localparam logic [KEY_W-1:0] KEY_LAST_LTR  = 4'd9;
  localparam logic [KEY_W-1:0] KEY_LAST_SYM  = 4'd10;
  localparam logic [KEY_W-1:0] KEY_DEL       = 4'd10;
  localparam logic [KEY_W-1:0] KEY_BKSP_ESC  = 4'd11;
  localparam logic [KEY_W-1:0] KEY_ENTER_CAP = 4'd12;
  localparam logic [KEY_W-1:0] KEY_CUT       = 4'd2;
  localparam logic [KEY_W-1:0] KEY_NEW       = 4'd3;
  localparam logic [KEY_W-1:0] KEY_REDO      = 4'd5;
  localparam logic [KEY_W-1:0] KEY_UNDO      = 4'd6;
  localparam logic [KEY_W-1:0] KEY_COPY      = 4'd8;
  localparam logic [KEY_W-1:0] KEY_PASTE     = 4'd9;

  // HID usage codes and modifier bits.
  localparam logic [7:0] USE_BKSP   = 8'h2A;
  localparam logic [7:0] USE_DELETE = 8'h4C;
  localparam logic [7:0] USE_ENTER  = 8'h28;
  localparam logic [7:0] USE_ESC    = 8'h29;
  localparam logic [7:0] USE_X      = 8'h1B;
  localparam logic [7:0] USE_Y      = 8'h1C;
  localparam logic [7:0] USE_Z      = 8'h1D;
  localparam logic [7:0] USE_N      = 8'h11;
  localparam logic [7:0] USE_C      = 8'h06;
  localparam logic [7:0] USE_V      = 8'h19;
  localparam logic [7:0] MOD_NONE   = 8'h00;
  localparam logic [7:0] MOD_CTRL   = 8'h01;
  localparam logic [7:0] MOD_SHIFT  = 8'h02;

  typedef struct packed {
    logic [7:0] usage;
    logic [7:0] mods;
    logic       last;
  } ev_t;

  typedef struct packed {
    logic [KEY_W-1:0] prev_key;
    logic [CD_W-1:0]  cd;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] last_key;
    logic             caps;
  } tap_state_t;

  typedef struct packed {
    logic [1:0] n;
    ev_t        ev0;
    ev_t        ev1;
  } dec_out_t;

  // Letter layer rows; an empty slot reads as zero usage.
  function automatic logic [7:0] letter_usage(input logic [KEY_W-1:0] key,
                                              input logic [POS_W-1:0] pos);
    logic [7:0] u;
    u = 8'h00;
    case ({key, pos})
      {4'd1, 3'd0}: u = 8'h2C;
      {4'd2, 3'd0}: u = 8'h04;
      {4'd2, 3'd1}: u = 8'h05;
      {4'd2, 3'd2}: u = 8'h06;
      {4'd3, 3'd0}: u = 8'h07;
      {4'd3, 3'd1}: u = 8'h08;
      {4'd3, 3'd2}: u = 8'h09;
      {4'd4, 3'd0}: u = 8'h0A;
      {4'd4, 3'd1}: u = 8'h0B;
      {4'd4, 3'd2}: u = 8'h0C;
      {4'd5, 3'd0}: u = 8'h0D;
      {4'd5, 3'd1}: u = 8'h0E;
      {4'd5, 3'd2}: u = 8'h0F;
      {4'd6, 3'd0}: u = 8'h10;
      {4'd6, 3'd1}: u = 8'h11;
      {4'd6, 3'd2}: u = 8'h12;
      {4'd7, 3'd0}: u = 8'h13;
      {4'd7, 3'd1}: u = 8'h14;
      {4'd7, 3'd2}: u = 8'h15;
      {4'd7, 3'd3}: u = 8'h16;
      {4'd8, 3'd0}: u = 8'h17;
      {4'd8, 3'd1}: u = 8'h18;
      {4'd8, 3'd2}: u = 8'h19;
      {4'd9, 3'd0}: u = 8'h1A;
      {4'd9, 3'd1}: u = 8'h1B;
      {4'd9, 3'd2}: u = 8'h1C;
      {4'd9, 3'd3}: u = 8'h1D;
      default:      u = 8'h00;
    endcase
    return u;
  endfunction

  // Symbol layer rows: usage code and modifier byte per slot.
  function automatic ev_t symbol_entry(input logic [KEY_W-1:0] key,
                                       input logic [POS_W-1:0] pos);
    logic [7:0] u;
    logic [7:0] m;
    u = 8'h00;
    m = MOD_NONE;
    case ({key, pos})
      {4'd1,  3'd0}: begin u = 8'h37; m = MOD_NONE;  end
      {4'd1,  3'd1}: begin u = 8'h36; m = MOD_NONE;  end
      {4'd1,  3'd2}: begin u = 8'h38; m = MOD_SHIFT; end
      {4'd2,  3'd0}: begin u = 8'h38; m = MOD_NONE;  end
      {4'd2,  3'd1}: begin u = 8'h31; m = MOD_NONE;  end
      {4'd2,  3'd2}: begin u = 8'h31; m = MOD_SHIFT; end
      {4'd3,  3'd0}: begin u = 8'h2F; m = MOD_NONE;  end
      {4'd3,  3'd1}: begin u = 8'h30; m = MOD_NONE;  end
      {4'd3,  3'd2}: begin u = 8'h23; m = MOD_SHIFT; end
      {4'd4,  3'd0}: begin u = 8'h2F; m = MOD_SHIFT; end
      {4'd4,  3'd1}: begin u = 8'h30; m = MOD_SHIFT; end
      {4'd4,  3'd2}: begin u = 8'h22; m = MOD_SHIFT; end
      {4'd5,  3'd0}: begin u = 8'h27; m = MOD_SHIFT; end
      {4'd5,  3'd1}: begin u = 8'h26; m = MOD_SHIFT; end
      {4'd5,  3'd2}: begin u = 8'h23; m = MOD_SHIFT; end
      {4'd6,  3'd0}: begin u = 8'h37; m = MOD_SHIFT; end
      {4'd6,  3'd1}: begin u = 8'h36; m = MOD_SHIFT; end
      {4'd6,  3'd2}: begin u = 8'h2D; m = MOD_SHIFT; end
      {4'd7,  3'd0}: begin u = 8'h2E; m = MOD_SHIFT; end
      {4'd7,  3'd1}: begin u = 8'h2D; m = MOD_NONE;  end
      {4'd7,  3'd2}: begin u = 8'h25; m = MOD_SHIFT; end
      {4'd8,  3'd0}: begin u = 8'h34; m = MOD_NONE;  end
      {4'd8,  3'd1}: begin u = 8'h34; m = MOD_SHIFT; end
      {4'd8,  3'd2}: begin u = 8'h35; m = MOD_SHIFT; end
      {4'd9,  3'd0}: begin u = 8'h1E; m = MOD_SHIFT; end
      {4'd9,  3'd1}: begin u = 8'h1F; m = MOD_SHIFT; end
      {4'd9,  3'd2}: begin u = 8'h20; m = MOD_SHIFT; end
      {4'd10, 3'd0}: begin u = 8'h2E; m = MOD_NONE;  end
      {4'd10, 3'd1}: begin u = 8'h24; m = MOD_SHIFT; end
      default:       begin u = 8'h00; m = MOD_NONE;  end
    endcase
    return '{usage: u, mods: m, last: 1'b0};
  endfunction

  function automatic ev_t tap_entry(input logic sym, input logic [KEY_W-1:0] key,
                                    input logic [POS_W-1:0] pos);
    ev_t e;
    if (sym) begin
      e = symbol_entry(key, pos);
    end else begin
      e = '{usage: letter_usage(key, pos), mods: MOD_NONE, last: 1'b0};
    end
    return e;
  endfunction

  function automatic logic [7:0] nav_usage(input logic [KEY_W-1:0] key);
    logic [7:0] u;
    u = 8'h00;
    case (key)
      4'd1:    u = 8'h2B;
      4'd2:    u = 8'h52;
      4'd3:    u = 8'h4B;
      4'd4:    u = 8'h50;
      4'd5:    u = 8'h51;
      4'd6:    u = 8'h4F;
      4'd7:    u = 8'h4A;
      4'd8:    u = 8'h4D;
      4'd9:    u = 8'h4E;
      4'd10:   u = 8'h44;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

  // Digit layer: keys 1 to 9 give digits 1 to 9, key 10 gives digit 0.
  function automatic logic [7:0] digit_usage(input logic [KEY_W-1:0] key);
    return 8'(8'h1D + {4'd0, key});
  endfunction

endpackage

>>> src/mtkhd_in_if.sv
interface mtkhd_in_if;
  import mtkhd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_number;
  logic [MODS_W-1:0] modifier_bits;

  modport source (output valid, output key_number, output modifier_bits, input ready);
  modport sink   (input valid, input key_number, input modifier_bits, output ready);
endinterface

>>> src/mtkhd_out_if.sv
interface mtkhd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] hid_usage;
  logic [7:0] hid_modifiers;
  logic       last_event;

  modport source (output valid, output hid_usage, output hid_modifiers, output last_event,
                  input ready);
  modport sink   (input valid, input hid_usage, input hid_modifiers, input last_event,
                  output ready);
endinterface

>>> src/multitap_keypad_to_hid_decoder.sv
// An item is registered in the input stage when it is accepted, decoded into the event queue
// once the queue has room for its events, and its first event is then offered on out_ch.
// Throughput: one item per cycle while the queue has room for two events; the out_ch port
// drains one event per cycle while the receiver is ready, so a two-event tick drains in turn.
// Reset (rst_n low, synchronous): tap state and caps clear, timeout reloads 800, queue empties.
module multitap_keypad_to_hid_decoder import mtkhd_pkg::*; #(
  parameter int unsigned EVQ_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CD_W-1:0]   cfg_wdata,
  mtkhd_in_if.sink          in_ch,
  mtkhd_out_if.source       out_ch
);

  // Timeout register: number of ticks during which a repeat tap cycles characters.
  logic [CD_W-1:0]   cfg_timeout_r;

  // Input register stage. It holds one scan tick until the queue can take its events.
  logic              s1_valid_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic [MODS_W-1:0] s1_mods_r;
  logic              s1_fire;
  logic              room;

  // Tap state carried from tick to tick.
  tap_state_t        st_r;
  tap_state_t        st_nxt;
  dec_out_t          dec;

  assign s1_fire     = s1_valid_r && room;
  assign in_ch.ready = !s1_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      cfg_timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // The payload stage needs no reset; it is only looked at while s1_valid_r is set.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_key_r  <= in_ch.key_number;
      s1_mods_r <= in_ch.modifier_bits;
    end
  end

  // Every tick that leaves the input stage updates the tap state, even when it emits nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  mtkhd_decode u_decode (
    .key     (s1_key_r),
    .mods    (s1_mods_r),
    .timeout (cfg_timeout_r),
    .st      (st_r),
    .dec     (dec),
    .st_nxt  (st_nxt)
  );

  // The queue reports room only when two more events fit, so a tick is never split.
  mtkhd_evq #(
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (s1_fire ? dec.n : 2'd0),
    .push_ev0 (dec.ev0),
    .push_ev1 (dec.ev1),
    .room     (room),
    .out_ch   (out_ch)
  );

  // A two-event tick is always a backspace followed by the final character.
  a_two_events: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (dec.n == 2'd2)) |-> ((dec.ev0.usage == USE_BKSP) && !dec.ev0.last &&
                                      dec.ev1.last))
    else $error("two-event tick without leading backspace");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (dec.n == 2'd1)) |-> dec.ev0.last)
    else $error("single event not marked last");

  a_prev_key: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (st_r.prev_key == $past(s1_key_r)))
    else $error("previous key not tracked");

endmodule

>>> src/mtkhd_decode.sv
module mtkhd_decode import mtkhd_pkg::*; (
  input  logic [KEY_W-1:0]  key,
  input  logic [MODS_W-1:0] mods,
  input  logic [CD_W-1:0]   timeout,
  input  tap_state_t        st,
  output dec_out_t          dec,
  output tap_state_t        st_nxt
);

  logic             cd_live;
  logic [CD_W-1:0]  cd_dec;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] p_sel;
  logic             press;
  logic             sym;
  logic             tap;
  logic             restart;
  logic             bksp;
  ev_t              ent_cur;
  ev_t              ent;
  logic             one_v;
  ev_t              one_ev;

  always_comb begin
    // The countdown runs every tick; an expired countdown drops the tap position.
    cd_live = (st.cd != '0);
    cd_dec  = cd_live ? CD_W'(st.cd - 10'd1) : '0;
    pos_cur = cd_live ? st.pos : '0;

    press = (st.prev_key == KEY_NONE) && (key != KEY_NONE);
    sym   = (mods == LAYER_SYMBOL);
    tap   = press && (((mods == LAYER_LETTER) && (key <= KEY_LAST_LTR)) ||
                      (sym && (key <= KEY_LAST_SYM)));

    restart = (cd_dec != '0) && (st.last_key != key);
    bksp    = (cd_dec != '0) && (st.last_key == key);
    ent_cur = tap_entry(sym, key, pos_cur);
    p_sel   = ((ent_cur.usage == 8'h00) || restart) ? '0 : pos_cur;
    ent     = tap_entry(sym, key, p_sel);
    if (!sym) begin
      ent.mods = st.caps ? MOD_SHIFT : MOD_NONE;
    end

    st_nxt          = st;
    st_nxt.prev_key = key;
    st_nxt.cd       = cd_dec;
    st_nxt.pos      = pos_cur;

    dec    = '0;
    one_v  = 1'b0;
    one_ev = '0;

    if (tap) begin
      st_nxt.cd       = timeout;
      st_nxt.pos      = POS_W'(p_sel + 3'd1);
      st_nxt.last_key = key;
      if (bksp) begin
        dec.n   = 2'd2;
        dec.ev0 = '{usage: USE_BKSP, mods: MOD_NONE, last: 1'b0};
        dec.ev1 = '{usage: ent.usage, mods: ent.mods, last: 1'b1};
      end else begin
        dec.n   = 2'd1;
        dec.ev0 = '{usage: ent.usage, mods: ent.mods, last: 1'b1};
      end
    end else if (press) begin
      if (mods == LAYER_LETTER) begin
        unique case (key)
          KEY_DEL:       begin one_v = 1'b1; one_ev.usage = USE_DELETE; end
          KEY_BKSP_ESC:  begin one_v = 1'b1; one_ev.usage = USE_BKSP;   end
          KEY_ENTER_CAP: begin one_v = 1'b1; one_ev.usage = USE_ENTER;  end
          default:       one_v = 1'b0;
        endcase
      end else if (sym) begin
        unique case (key)
          KEY_BKSP_ESC:  begin one_v = 1'b1; one_ev.usage = USE_ESC; end
          KEY_ENTER_CAP: st_nxt.caps = ~st.caps;
          default:       one_v = 1'b0;
        endcase
      end else if ((mods == LAYER_NAV) && (key <= KEY_LAST_SYM)) begin
        one_v        = 1'b1;
        one_ev.usage = nav_usage(key);
      end else if ((mods == LAYER_DIGIT) && (key <= KEY_LAST_SYM)) begin
        one_v        = 1'b1;
        one_ev.usage = digit_usage(key);
      end else if (mods == LAYER_CTRL) begin
        unique case (key)
          KEY_CUT:   begin one_v = 1'b1; one_ev.usage = USE_Y; end
          KEY_NEW:   begin one_v = 1'b1; one_ev.usage = USE_N; end
          KEY_REDO:  begin one_v = 1'b1; one_ev.usage = USE_X; one_ev.mods = MOD_CTRL; end
          KEY_UNDO:  begin one_v = 1'b1; one_ev.usage = USE_Z; one_ev.mods = MOD_CTRL; end
          KEY_COPY:  begin
            one_v = 1'b1;
            one_ev.usage = USE_C;
            one_ev.mods  = st.caps ? (MOD_CTRL | MOD_SHIFT) : MOD_CTRL;
          end
          KEY_PASTE: begin
            one_v = 1'b1;
            one_ev.usage = USE_V;
            one_ev.mods  = st.caps ? (MOD_CTRL | MOD_SHIFT) : MOD_CTRL;
          end
          default:   one_v = 1'b0;
        endcase
      end
      if (one_v) begin
        dec.n   = 2'd1;
        dec.ev0 = '{usage: one_ev.usage, mods: one_ev.mods, last: 1'b1};
      end
    end
  end

endmodule

>>> src/mtkhd_evq.sv
module mtkhd_evq import mtkhd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_n,
  input  ev_t         push_ev0,
  input  ev_t         push_ev1,
  output logic        room,
  mtkhd_out_if.source out_ch
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ev_t           mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wr_ptr_1;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign pop      = out_ch.valid && out_ch.ready;
  assign wr_ptr_1 = ptr_inc(wr_ptr_r);
  assign room     = (cnt_r <= CW'(DEPTH - 2));

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.hid_usage     = mem_r[rd_ptr_r].usage;
  assign out_ch.hid_modifiers = mem_r[rd_ptr_r].mods;
  assign out_ch.last_event    = mem_r[rd_ptr_r].last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr_ptr_1;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = CW'(cnt_r + CW'(push_n) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_ev0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_1] <= push_ev1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("event queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room)
    else $error("event pushed without room for a full tick");

endmodule

>>> tb/tb_multitap_keypad_to_hid_decoder.sv
module tb_multitap_keypad_to_hid_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import mtkhd_pkg::*;

  // The run is stopped here even if the block hangs.
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  // Cycles to let pass after the last expected event, since a release tick
  // gives no event but may still be in the block's pipeline.
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned PHASE_PRESSES   = 33;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned REPORT_CAP      = 200;
  // Release runs sized to the tap window are only used for windows up to this.
  localparam int unsigned WINDOW_RUN_MAX  = 40;

  // One scan tick as it goes over the input channel.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MODS_W-1:0] layer;
  } scan_tick_t;

  // Multi-tap rows of the letter layer, one row per key, 0 marks an empty slot.
  localparam logic [0:9][0:3][7:0] LETTER_USAGE = {
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h2C, 8'h00, 8'h00, 8'h00,
    8'h04, 8'h05, 8'h06, 8'h00,
    8'h07, 8'h08, 8'h09, 8'h00,
    8'h0A, 8'h0B, 8'h0C, 8'h00,
    8'h0D, 8'h0E, 8'h0F, 8'h00,
    8'h10, 8'h11, 8'h12, 8'h00,
    8'h13, 8'h14, 8'h15, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h00,
    8'h1A, 8'h1B, 8'h1C, 8'h1D
  };

  // Multi-tap rows of the symbol layer, and which of those slots need shift.
  localparam logic [0:10][0:3][7:0] SYMBOL_USAGE = {
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h37, 8'h36, 8'h38, 8'h00,
    8'h38, 8'h31, 8'h31, 8'h00,
    8'h2F, 8'h30, 8'h23, 8'h00,
    8'h2F, 8'h30, 8'h22, 8'h00,
    8'h27, 8'h26, 8'h23, 8'h00,
    8'h37, 8'h36, 8'h2D, 8'h00,
    8'h2E, 8'h2D, 8'h25, 8'h00,
    8'h34, 8'h34, 8'h35, 8'h00,
    8'h1E, 8'h1F, 8'h20, 8'h00,
    8'h2E, 8'h24, 8'h00, 8'h00
  };

  localparam logic [0:10][0:3] SYMBOL_SHIFT = {
    4'b0000, 4'b0010, 4'b0010, 4'b0010, 4'b1110, 4'b1110,
    4'b1110, 4'b1010, 4'b0110, 4'b1110, 4'b0100
  };

  // Navigation layer: tab, arrows, home, end, page keys and F11.
  localparam logic [0:10][7:0] NAV_USAGE = {
    8'h00, 8'h2B, 8'h52, 8'h4B, 8'h50, 8'h51, 8'h4F, 8'h4A, 8'h4D, 8'h4E, 8'h44
  };

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  logic [CD_W-1:0] cfg_wdata;

  mtkhd_in_if  in_if ();
  mtkhd_out_if out_if ();

  multitap_keypad_to_hid_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Scan ticks waiting to be offered, and the HID events the decoder owes us.
  scan_tick_t  scan_ticks[$];
  ev_t         expected_hid_events[$];
  int unsigned ticks_queued   = 0;
  int unsigned ticks_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Our own copy of the decoder state and of its timeout register.
  logic [CD_W-1:0]  repeat_window = TIMEOUT_RESET;
  logic [KEY_W-1:0] prev_key      = KEY_NONE;
  logic [CD_W-1:0]  countdown     = '0;
  logic [POS_W-1:0] tap_pos       = '0;
  logic [KEY_W-1:0] tapped_key    = KEY_NONE;
  logic             caps_on       = 1'b0;

  // Idling controls, set per phase by the stimulus process.
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit pressure_armed = 1'b0;
  bit pressure_done  = 1'b0;

  function automatic ev_t hid_event(input logic [7:0] usage, input logic [7:0] mods);
    return '{usage: usage, mods: mods, last: 1'b0};
  endfunction

  // Character at one slot of a multi-tap row. Slots past the end of a row are
  // empty, which sends the tap back to the first slot.
  function automatic ev_t tap_slot(input logic sym, input logic [KEY_W-1:0] key,
                                   input logic [POS_W-1:0] pos);
    ev_t slot;
    slot = hid_event(8'h00, MOD_NONE);
    if (pos < 3'd4) begin
      if (sym && key <= KEY_LAST_SYM) begin
        slot.usage = SYMBOL_USAGE[key][pos[1:0]];
        slot.mods  = SYMBOL_SHIFT[key][pos[1:0]] ? MOD_SHIFT : MOD_NONE;
      end else if (!sym && key <= KEY_LAST_LTR) begin
        slot.usage = LETTER_USAGE[key][pos[1:0]];
      end
    end
    return slot;
  endfunction

  // Advances the decoder state by one scan tick and queues the events it owes.
  task automatic decode_tick(input scan_tick_t tick);
    ev_t              evs[$];
    ev_t              slot;
    logic             sym;
    logic [POS_W-1:0] p;
    logic [7:0]       combo_mods;
    // The tap timer runs on every tick, pressed or not. Once it has run out,
    // the tap position falls back to the first slot.
    if (countdown != '0) begin
      countdown = countdown - 1'b1;
    end else begin
      tap_pos = '0;
    end
    combo_mods = caps_on ? (MOD_CTRL | MOD_SHIFT) : MOD_CTRL;
    // Only a fresh press, after a tick with every key released, does anything.
    if (prev_key == KEY_NONE && tick.key != KEY_NONE) begin
      case (tick.layer)
        LAYER_LETTER, LAYER_SYMBOL: begin
          sym = (tick.layer == LAYER_SYMBOL);
          if ((!sym && tick.key > KEY_LAST_LTR) || (sym && tick.key > KEY_LAST_SYM)) begin
            // Control keys above the multi-tap rows.
            if (!sym) begin
              case (tick.key)
                KEY_DEL:       evs.push_back(hid_event(USE_DELETE, MOD_NONE));
                KEY_BKSP_ESC:  evs.push_back(hid_event(USE_BKSP, MOD_NONE));
                KEY_ENTER_CAP: evs.push_back(hid_event(USE_ENTER, MOD_NONE));
                default: ;
              endcase
            end else begin
              case (tick.key)
                KEY_BKSP_ESC:  evs.push_back(hid_event(USE_ESC, MOD_NONE));
                KEY_ENTER_CAP: caps_on = ~caps_on;
                default: ;
              endcase
            end
          end else begin
            p    = tap_pos;
            slot = tap_slot(sym, tick.key, p);
            if (slot.usage == 8'h00) begin
              p    = '0;
              slot = tap_slot(sym, tick.key, p);
            end
            // Still inside the tap window: the same key replaces the character
            // it typed last, another key starts its own row from the top.
            if (countdown != '0) begin
              if (tapped_key != tick.key) begin
                p    = '0;
                slot = tap_slot(sym, tick.key, p);
              end else begin
                evs.push_back(hid_event(USE_BKSP, MOD_NONE));
              end
            end
            if (!sym && caps_on) begin
              slot.mods = MOD_SHIFT;
            end
            evs.push_back(slot);
            countdown  = repeat_window;
            tap_pos    = p + 1'b1;
            tapped_key = tick.key;
          end
        end
        LAYER_NAV: begin
          if (tick.key <= KEY_DEL) begin
            evs.push_back(hid_event(NAV_USAGE[tick.key], MOD_NONE));
          end
        end
        LAYER_DIGIT: begin
          // Keys 1 to 9 give their digit and key 10 gives zero, in HID order.
          if (tick.key <= KEY_DEL) begin
            evs.push_back(hid_event(8'h1D + {4'd0, tick.key}, MOD_NONE));
          end
        end
        LAYER_CTRL: begin
          case (tick.key)
            KEY_CUT:   evs.push_back(hid_event(USE_Y, MOD_NONE));
            KEY_NEW:   evs.push_back(hid_event(USE_N, MOD_NONE));
            KEY_REDO:  evs.push_back(hid_event(USE_X, MOD_CTRL));
            KEY_UNDO:  evs.push_back(hid_event(USE_Z, MOD_CTRL));
            KEY_COPY:  evs.push_back(hid_event(USE_C, combo_mods));
            KEY_PASTE: evs.push_back(hid_event(USE_V, combo_mods));
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    prev_key = tick.key;
    if (evs.size() != 0) begin
      evs[evs.size()-1].last = 1'b1;
    end
    foreach (evs[i]) begin
      expected_hid_events.push_back(evs[i]);
    end
  endtask

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int unsigned draw_pause(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) begin
      return 0;
    end else if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(12, 40);
  endfunction

  // Driver: offers one scan tick at a time and holds it until it is taken.
  // Each taken item runs through the decoder model right away.
  always @(posedge clk) begin : drive_ticks
    scan_tick_t  nxt;
    scan_tick_t  seen;
    logic        took;
    int unsigned gap_left;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_if.valid && in_if.ready;
      if (took) begin
        seen.key   = in_if.key_number;
        seen.layer = in_if.modifier_bits;
        decode_tick(seen);
        ticks_accepted++;
      end
      if (in_if.valid && !took) begin
        // The item on offer stays put until the decoder takes it.
      end else if (gap_left != 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (scan_ticks.size() != 0) begin
        nxt = scan_ticks.pop_front();
        in_if.valid         <= 1'b1;
        in_if.key_number    <= nxt.key;
        in_if.modifier_bits <= nxt.layer;
        gap_left = draw_pause(sender_idles);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: ready comes and goes at random. Once in the run it holds off
  // for a long stretch so that the event queue fills and the input stalls.
  always @(posedge clk) begin : pace_events
    int unsigned stall_left;
    int unsigned hold_left;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (pressure_armed && !pressure_done) begin
        hold_left     = HOLD_OFF_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = draw_pause(receiver_idles);
      end
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $error("%s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  // Monitor: every event taken from the decoder is checked against the
  // oldest one still owed.
  always @(posedge clk) begin : check_events
    ev_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_hid_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP) begin
          $error("unexpected event: hid_usage 0x%0h, hid_modifiers 0x%0h, last_event %0b",
                 out_if.hid_usage, out_if.hid_modifiers, out_if.last_event);
        end
      end else begin
        want = expected_hid_events.pop_front();
        if (out_if.hid_usage !== want.usage) begin
          flag_mismatch("hid_usage", want.usage, out_if.hid_usage);
        end
        if (out_if.hid_modifiers !== want.mods) begin
          flag_mismatch("hid_modifiers", want.mods, out_if.hid_modifiers);
        end
        if (out_if.last_event !== want.last) begin
          flag_mismatch("last_event", want.last, out_if.last_event);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_tick(input logic [KEY_W-1:0] key, input logic [MODS_W-1:0] layer);
    scan_tick_t t;
    t.key   = key;
    t.layer = layer;
    scan_ticks.push_back(t);
    ticks_queued++;
  endtask

  // Waits until every queued tick is taken and every owed event has come
  // out, then gives the pipeline time to finish any silent ticks.
  task automatic settle();
    while (ticks_accepted != ticks_queued || expected_hid_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The block must be idle here; the model takes the new window at once.
  task automatic write_window(input logic [CD_W-1:0] window);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= window;
    repeat_window = window;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random typing: mostly presses followed by releases, so that the tap
  // logic gets exercised, with repeats of the same key to walk the rows.
  // With a short tap window, release runs are sometimes sized around it so
  // that taps land just before, on and just after the tick where the window
  // runs out. Now and then a second key is pressed while one is held, which
  // must be ignored.
  task automatic queue_random_taps(input int unsigned presses);
    logic [KEY_W-1:0]  key;
    logic [MODS_W-1:0] layer;
    logic [KEY_W-1:0]  last_press;
    int unsigned       r;
    int                releases;
    last_press = KEY_NONE;
    repeat (presses) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        layer = LAYER_LETTER;
      end else if (r < 62) begin
        layer = LAYER_SYMBOL;
      end else if (r < 70) begin
        layer = LAYER_NAV;
      end else if (r < 78) begin
        layer = LAYER_DIGIT;
      end else if (r < 88) begin
        layer = LAYER_CTRL;
      end else begin
        layer = MODS_W'($urandom_range(0, 15));
      end
      r = $urandom_range(0, 99);
      if (r < 55 && last_press != KEY_NONE) begin
        key = last_press;
      end else if (r < 82) begin
        key = KEY_W'($urandom_range(1, 10));
      end else begin
        key = KEY_W'($urandom_range(0, 15));
      end
      if (key != KEY_NONE) begin
        last_press = key;
      end
      queue_tick(key, layer);
      if ($urandom_range(0, 9) == 0) begin
        queue_tick(KEY_W'($urandom_range(1, 15)), MODS_W'($urandom_range(0, 15)));
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        releases = 1;
      end else if (r < 88) begin
        releases = int'($urandom_range(1, 4));
      end else if (repeat_window <= CD_W'(WINDOW_RUN_MAX)) begin
        releases = int'(repeat_window) - 1 + int'($urandom_range(0, 2));
      end else begin
        releases = int'($urandom_range(1, 4));
      end
      if (releases < 1) begin
        releases = 1;
      end
      repeat (releases) begin
        queue_tick(KEY_NONE, MODS_W'($urandom_range(0, 15)));
      end
    end
  endtask

  task automatic run_phase(input logic [CD_W-1:0] window, input bit sender_gaps,
                           input bit receiver_gaps, input bit squeeze);
    write_window(window);
    sender_idles   = sender_gaps;
    receiver_idles = receiver_gaps;
    if (squeeze) begin
      pressure_armed = 1'b1;
    end
    queue_random_taps(PHASE_PRESSES);
    settle();
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed typing with the window at its reset value.
    queue_tick(4'd2, LAYER_LETTER);          // first tap on a row
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(4'd2, LAYER_LETTER);          // same key again: backspace, next slot
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(4'd9, LAYER_SYMBOL);          // other key inside the window: no backspace
    queue_tick(KEY_NONE, 4'hF);
    queue_tick(KEY_ENTER_CAP, LAYER_SYMBOL); // caps toggles silently
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(4'hF, LAYER_LETTER);          // key with no function in the letter layer
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(KEY_DEL, LAYER_LETTER);
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(KEY_BKSP_ESC, LAYER_SYMBOL);
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(4'd10, LAYER_NAV);
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(4'd10, LAYER_DIGIT);
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(KEY_COPY, LAYER_CTRL);        // copy picks up shift from caps
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(4'd5, 4'd4);                  // layer with no function
    queue_tick(KEY_NONE, LAYER_LETTER);
    queue_tick(4'd1, LAYER_LETTER);          // space, shifted by caps
    queue_tick(4'hE, 4'hF);                  // second key while one is held
    queue_tick(KEY_NONE, LAYER_LETTER);
    settle();

    queue_random_taps(PHASE_PRESSES);
    settle();

    // Window settings, the extremes among them. The long receiver hold-off
    // comes in the widest window, with the sender offering back to back.
    run_phase(10'd2, 1'b1, 1'b1, 1'b0);
    run_phase(10'd1023, 1'b0, 1'b1, 1'b1);
    run_phase(10'd1, 1'b1, 1'b0, 1'b0);
    run_phase(10'd0, 1'b0, 1'b0, 1'b0);
    run_phase(10'd5, 1'b1, 1'b1, 1'b0);
    run_phase(10'd3, 1'b0, 1'b1, 1'b0);
    run_phase(CD_W'($urandom_range(6, 40)), 1'b1, 1'b0, 1'b0);
    run_phase(TIMEOUT_RESET, 1'b1, 1'b1, 1'b0);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
